FILE: sv/lct_pkg.sv
// Package: types and constants for the connection table with timers.
`timescale 1ns / 1ps
package lct_pkg;
  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W = 4;
  localparam int NUM_TIMERS = 3;
  localparam logic [31:0] MAX_WAIT_RESET = 32'd3600000;

  typedef enum logic [2:0] {
    CMD_FIND   = 3'd0,
    CMD_ALLOC  = 3'd1,
    CMD_ACTIVE = 3'd2,
    CMD_ARM    = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_FOUND   = 3'd0,
    ST_ALLOC   = 3'd1,
    ST_FULL    = 3'd2,
    ST_NOTFND  = 3'd3,
    ST_EXPIRED = 3'd4,
    ST_DONE    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TICK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0]  port;
    logic [55:0] local_addr;
    logic [55:0] remote_addr;
  } key_t;
endpackage

FILE: sv/link_connection_table_with_timers_core.sv
// Top level: connection table with timers, memory-based sequential scan.
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_stall   | cmd, port, addrs, entry, active, timer_sel, time
// out_    | output    | out_valid/out_stall | status, entry_index, expired_timer, next_wait, last
// cfg_    | input     | cfg_we              | max_wait
// Keys live in a 16-entry memory and deadlines in a 48-entry memory, each with
// registered reads. Find/allocate walks entries one per cycle and stops at the
// first active match or the last entry, then gives its result from S_EMIT.
// Tick walks all 48 timers one per cycle while the output is free; the walk holds
// while a pending expiry sits stalled on the output, then gives the done result.
// Set active and arm go from idle straight to S_EMIT. in_stall stays high until the
// last result is taken. Reset clears the active flags and the key and timer valid
// bits; a cleared bit reads as zero.
module link_connection_table_with_timers_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_max_wait,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_port,
  input  logic [55:0] in_local_addr,
  input  logic [55:0] in_remote_addr,
  input  logic [3:0]  in_entry,
  input  logic        in_active,
  input  logic [1:0]  in_timer_sel,
  input  logic [31:0] in_time_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_entry_index,
  output logic [1:0]  out_expired_timer,
  output logic [31:0] out_next_wait,
  output logic        out_last
);
  import lct_pkg::*;

  localparam int TN = NUM_ENTRIES * NUM_TIMERS;
  localparam int TW = $clog2(TN);

  // key memory, timer memory
  key_t        key_mem [NUM_ENTRIES];
  logic [31:0] tmr_mem [TN];
  key_t        key_rd_r;
  logic [31:0] tmr_rd_r;
  // active flags, key valid bits and timer-armed valid bits (a cleared bit reads as zero)
  logic [NUM_ENTRIES-1:0] used_r, used_nxt;
  logic [NUM_ENTRIES-1:0] kval_r, kval_nxt;
  logic [TN-1:0]          tval_r, tval_nxt;

  state_t state_r, state_nxt;
  logic [2:0]  cmd_r;
  key_t        key_r;
  logic [3:0]  ent_r;
  logic        act_r;
  logic [1:0]  sel_r;
  logic [31:0] tv_r;
  logic [31:0] max_wait_r;
  logic [31:0] wait_r, wait_nxt;

  // scan pointers: issue address and address of data now in the read register
  logic [IDX_W:0] kaddr_r, kaddr_nxt;
  logic [IDX_W-1:0] kdat_r, kdat_nxt;
  logic           kdv_r, kdv_nxt;
  logic [TW:0]    taddr_r, taddr_nxt;
  logic [TW-1:0]  tdat_r, tdat_nxt;
  logic           tdv_r, tdv_nxt;
  logic [IDX_W:0] free_r, free_nxt;  // MSB set means none
  // entry/timer of the next issue address and of the data in the read register
  logic [IDX_W-1:0] ient_r, ient_nxt;
  logic [1:0]       itm_r, itm_nxt;
  logic [IDX_W-1:0] tent_r, tent_nxt;
  logic [1:0]       ttm_r, ttm_nxt;

  logic        ov_r, ov_nxt;
  logic [2:0]  os_r, os_nxt;
  logic [3:0]  oi_r, oi_nxt;
  logic [1:0]  ot_r, ot_nxt;
  logic [31:0] ow_r, ow_nxt;
  logic        ol_r, ol_nxt;

  logic        kwe;
  logic [IDX_W-1:0] kwa;
  logic        twe;
  logic [TW-1:0] twa;
  logic [31:0] twd;

  logic        take;
  logic        oroom;
  logic        trd;
  key_t        kdat_key;
  logic [31:0] dl;
  logic [TW+1:0] arm_idx;

  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign take = in_valid && !in_stall;
  assign oroom = !ov_r || !out_stall;
  // timer read register holds while the tick scan waits on the output
  assign trd = (state_r != S_TICK) || !tdv_r || oroom;
  assign kdat_key = kval_r[kdat_r] ? key_rd_r : '0;
  assign dl = tval_r[tdat_r] ? tmr_rd_r : 32'd0;
  assign arm_idx = (TW+2)'(ent_r) * (TW+2)'(NUM_TIMERS) + (TW+2)'(sel_r);

  always_ff @(posedge clk) begin
    if (kwe) key_mem[kwa] <= key_r;
    key_rd_r <= key_mem[kaddr_r[IDX_W-1:0]];
    if (twe) tmr_mem[twa] <= twd;
    if (trd) tmr_rd_r <= tmr_mem[taddr_r[TW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (take) begin
        unique case (in_cmd)
          CMD_FIND, CMD_ALLOC: state_nxt = S_SCAN;
          CMD_TICK:            state_nxt = S_TICK;
          default:             state_nxt = S_EMIT;
        endcase
      end
      S_SCAN: if (kdv_r && (used_r[kdat_r] && kdat_key == key_r
                  || kdat_r == IDX_W'(NUM_ENTRIES - 1))) state_nxt = S_EMIT;
      S_TICK: if (tdv_r && tdat_r == TW'(TN - 1) && oroom) state_nxt = S_EMIT;
      S_EMIT: if (oroom) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    used_nxt = used_r; kval_nxt = kval_r; tval_nxt = tval_r; wait_nxt = wait_r;
    kaddr_nxt = kaddr_r; kdat_nxt = kdat_r; kdv_nxt = 1'b0;
    taddr_nxt = taddr_r; tdat_nxt = tdat_r; tdv_nxt = tdv_r;
    ient_nxt = ient_r; itm_nxt = itm_r; tent_nxt = tent_r; ttm_nxt = ttm_r;
    free_nxt = free_r;
    ov_nxt = ov_r && out_stall;
    os_nxt = os_r; oi_nxt = oi_r; ot_nxt = ot_r; ow_nxt = ow_r; ol_nxt = ol_r;
    kwe = 1'b0; kwa = '0; twe = 1'b0; twa = '0; twd = '0;
    unique case (state_r)
      S_IDLE: begin
        kaddr_nxt = '0; taddr_nxt = '0; tdv_nxt = 1'b0;
        ient_nxt = '0; itm_nxt = '0;
        free_nxt = {1'b1, {IDX_W{1'b0}}};
        wait_nxt = max_wait_r;
      end
      S_SCAN: begin
        if (kaddr_r < (IDX_W+1)'(NUM_ENTRIES)) begin
          kdat_nxt = kaddr_r[IDX_W-1:0]; kdv_nxt = 1'b1;
          kaddr_nxt = kaddr_r + 1'b1;
        end
        if (kdv_r) begin
          if (!used_r[kdat_r]) free_nxt = {1'b0, kdat_r};
          if (used_r[kdat_r] && kdat_key == key_r) begin
            kaddr_nxt = (IDX_W+1)'(NUM_ENTRIES); kdv_nxt = 1'b0;
            os_nxt = ST_FOUND; oi_nxt = kdat_r;
          end else if (kdat_r == IDX_W'(NUM_ENTRIES - 1)) begin
            oi_nxt = '0;
            if (cmd_r == CMD_FIND) os_nxt = ST_NOTFND;
            else if (used_r[kdat_r] && free_r[IDX_W]) os_nxt = ST_FULL;
            else begin
              os_nxt = ST_ALLOC;
              kwa = used_r[kdat_r] ? free_r[IDX_W-1:0] : kdat_r;
              oi_nxt = kwa; kwe = 1'b1;
              used_nxt[kwa] = 1'b0;
              kval_nxt[kwa] = 1'b1;
              for (int t = 0; t < NUM_TIMERS; t++)
                tval_nxt[TW'(kwa * NUM_TIMERS + t)] = 1'b0;
            end
          end
        end
      end
      S_TICK: begin
        if (!tdv_r || oroom) begin
          if (tdv_r) begin
            if (used_r[tent_r] && dl != 32'd0) begin
              if (dl <= tv_r) begin
                tval_nxt[tdat_r] = 1'b0;
                ov_nxt = 1'b1; os_nxt = ST_EXPIRED; oi_nxt = tent_r; ot_nxt = ttm_r;
                ow_nxt = '0; ol_nxt = 1'b0;
              end else if (dl - tv_r < wait_nxt) wait_nxt = dl - tv_r;
            end
          end
          if (taddr_r < (TW+1)'(TN)) begin
            tdat_nxt = taddr_r[TW-1:0]; tdv_nxt = 1'b1; taddr_nxt = taddr_r + 1'b1;
            tent_nxt = ient_r; ttm_nxt = itm_r;
            if (itm_r == 2'(NUM_TIMERS - 1)) begin
              itm_nxt = '0; ient_nxt = ient_r + 1'b1;
            end else itm_nxt = itm_r + 1'b1;
          end else tdv_nxt = 1'b0;
        end
      end
      S_EMIT: if (oroom) begin
        ov_nxt = 1'b1; ol_nxt = 1'b1; ot_nxt = '0; ow_nxt = '0;
        unique case (cmd_r)
          CMD_FIND, CMD_ALLOC: ;
          CMD_TICK: begin os_nxt = ST_DONE; oi_nxt = '0; ow_nxt = wait_r; end
          CMD_ACTIVE: begin
            os_nxt = ST_DONE; oi_nxt = '0;
            if (32'(ent_r) < NUM_ENTRIES) used_nxt[ent_r] = act_r;
          end
          CMD_ARM: begin
            os_nxt = ST_DONE; oi_nxt = '0;
            if (32'(ent_r) < NUM_ENTRIES && sel_r != 2'd3) begin
              twe = 1'b1; twa = arm_idx[TW-1:0]; twd = tv_r;
              tval_nxt[twa] = 1'b1;
            end
          end
          default: begin os_nxt = ST_DONE; oi_nxt = '0; end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; used_r <= '0; kval_r <= '0; tval_r <= '0; ov_r <= 1'b0;
      max_wait_r <= MAX_WAIT_RESET; kdv_r <= 1'b0; tdv_r <= 1'b0;
      kaddr_r <= '0; taddr_r <= '0; free_r <= '0;
    end else begin
      state_r <= state_nxt; used_r <= used_nxt; kval_r <= kval_nxt;
      tval_r <= tval_nxt; ov_r <= ov_nxt;
      kdv_r <= kdv_nxt; tdv_r <= tdv_nxt; kaddr_r <= kaddr_nxt; taddr_r <= taddr_nxt;
      free_r <= free_nxt;
      if (cfg_we) max_wait_r <= cfg_max_wait;
    end
  end

  always_ff @(posedge clk) begin
    kdat_r <= kdat_nxt; tdat_r <= tdat_nxt; wait_r <= wait_nxt;
    ient_r <= ient_nxt; itm_r <= itm_nxt; tent_r <= tent_nxt; ttm_r <= ttm_nxt;
    os_r <= os_nxt; oi_r <= oi_nxt; ot_r <= ot_nxt; ow_r <= ow_nxt; ol_r <= ol_nxt;
    if (take) begin
      cmd_r <= in_cmd; key_r <= '{in_port, in_local_addr, in_remote_addr};
      ent_r <= in_entry; act_r <= in_active; sel_r <= in_timer_sel;
      tv_r <= in_time_value;
    end
  end

  assign out_valid = ov_r;
  assign out_status = os_r;
  assign out_entry_index = oi_r;
  assign out_expired_timer = ot_r;
  assign out_next_wait = ow_r;
  assign out_last = ol_r;
endmodule

FILE: sim/tb_link_connection_table_with_timers_core.sv
// Testbench: connection table with timers, self-checking against a local predictor.
`timescale 1ns / 1ps
module tb_link_connection_table_with_timers_core;
  import lct_pkg::*;

  // one request as driven onto the in_ channel
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  port;
    logic [55:0] local_addr;
    logic [55:0] remote_addr;
    logic [3:0]  entry;
    logic        active;
    logic [1:0]  timer_sel;
    logic [31:0] time_value;
  } req_t;

  // one expected result on the out_ channel
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  entry_index;
    logic [1:0]  expired_timer;
    logic [31:0] next_wait;
    logic        last;
  } rsp_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_max_wait;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_cmd;
  logic [7:0]  in_port;
  logic [55:0] in_local_addr;
  logic [55:0] in_remote_addr;
  logic [3:0]  in_entry;
  logic        in_active;
  logic [1:0]  in_timer_sel;
  logic [31:0] in_time_value;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [3:0]  out_entry_index;
  logic [1:0]  out_expired_timer;
  logic [31:0] out_next_wait;
  logic        out_last;

  link_connection_table_with_timers_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_max_wait(cfg_max_wait),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_port(in_port),
    .in_local_addr(in_local_addr), .in_remote_addr(in_remote_addr),
    .in_entry(in_entry), .in_active(in_active), .in_timer_sel(in_timer_sel),
    .in_time_value(in_time_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_entry_index(out_entry_index), .out_expired_timer(out_expired_timer),
    .out_next_wait(out_next_wait), .out_last(out_last)
  );

  // Shadow copy of the table, timers and the max_wait register.
  logic        sh_used   [NUM_ENTRIES];
  logic [7:0]  sh_port   [NUM_ENTRIES];
  logic [55:0] sh_local  [NUM_ENTRIES];
  logic [55:0] sh_remote [NUM_ENTRIES];
  logic [31:0] sh_dead   [NUM_ENTRIES*NUM_TIMERS];
  logic [31:0] sh_max_wait;

  req_t pending_reqs[$];    // filled by the stimulus, drained by the driver
  rsp_t expected_rsps[$];   // oldest at the front

  int     mismatches = 0;
  int     reqs_sent = 0;
  int     rsps_seen = 0;
  int     expiries_seen = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_sender = 0;
  bit     in_taken = 0;       // request accepted at the last rising edge

  // Known keys, so random lookups hit populated entries often.
  logic [7:0]  key_port   [8];
  logic [55:0] key_local  [8];
  logic [55:0] key_remote [8];
  logic [31:0] now_time;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rsp_t mk_rsp(status_t st, logic [3:0] idx, logic [1:0] tmr,
                                  logic [31:0] wait_val, logic lst);
    rsp_t r;
    r.status = st;
    r.entry_index = idx;
    r.expired_timer = tmr;
    r.next_wait = wait_val;
    r.last = lst;
    return r;
  endfunction

  task automatic table_reset();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      sh_used[i] = 1'b0;
      sh_port[i] = '0;
      sh_local[i] = '0;
      sh_remote[i] = '0;
    end
    for (int i = 0; i < NUM_ENTRIES*NUM_TIMERS; i++) sh_dead[i] = '0;
    sh_max_wait = MAX_WAIT_RESET;
  endtask

  // Advance the shadow table by one accepted request, queue what it must produce.
  task automatic table_apply(req_t q);
    int          free_idx;
    logic [31:0] wait_val;
    logic [31:0] d;
    free_idx = -1;
    case (q.cmd)
      CMD_FIND, CMD_ALLOC: begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (sh_used[i] && sh_port[i] == q.port && sh_local[i] == q.local_addr &&
              sh_remote[i] == q.remote_addr) begin
            expected_rsps.push_back(mk_rsp(ST_FOUND, 4'(i), 0, 0, 1'b1));
            return;
          end
          if (!sh_used[i]) free_idx = i;
        end
        if (q.cmd == CMD_FIND) begin
          expected_rsps.push_back(mk_rsp(ST_NOTFND, 0, 0, 0, 1'b1));
        end else if (free_idx < 0) begin
          expected_rsps.push_back(mk_rsp(ST_FULL, 0, 0, 0, 1'b1));
        end else begin
          // slot takes the key but stays inactive until set active
          sh_port[free_idx] = q.port;
          sh_local[free_idx] = q.local_addr;
          sh_remote[free_idx] = q.remote_addr;
          for (int t = 0; t < NUM_TIMERS; t++) sh_dead[free_idx*NUM_TIMERS+t] = '0;
          expected_rsps.push_back(mk_rsp(ST_ALLOC, 4'(free_idx), 0, 0, 1'b1));
        end
      end
      CMD_ACTIVE: begin
        sh_used[q.entry] = q.active;
        expected_rsps.push_back(mk_rsp(ST_DONE, 0, 0, 0, 1'b1));
      end
      CMD_ARM: begin
        // selector 3 is a no-op
        if (q.timer_sel < NUM_TIMERS) sh_dead[q.entry*NUM_TIMERS+q.timer_sel] = q.time_value;
        expected_rsps.push_back(mk_rsp(ST_DONE, 0, 0, 0, 1'b1));
      end
      CMD_TICK: begin
        wait_val = sh_max_wait;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (!sh_used[i]) continue;
          for (int t = 0; t < NUM_TIMERS; t++) begin
            d = sh_dead[i*NUM_TIMERS+t];
            if (d == 0) continue;
            if (d <= q.time_value) begin
              sh_dead[i*NUM_TIMERS+t] = '0;
              expected_rsps.push_back(mk_rsp(ST_EXPIRED, 4'(i), 2'(t), 0, 1'b0));
            end else if (d - q.time_value < wait_val) begin
              wait_val = d - q.time_value;
            end
          end
        end
        expected_rsps.push_back(mk_rsp(ST_DONE, 0, 0, wait_val, 1'b1));
      end
      default: expected_rsps.push_back(mk_rsp(ST_DONE, 0, 0, 0, 1'b1));
    endcase
  endtask

  // Acceptance is judged on the values seen at the rising edge.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // Driver: inputs change on the falling edge; a held request stays put.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_taken || !in_valid) begin
        if (in_taken) begin
          // previous request was taken on the last rising edge
          table_apply(pending_reqs.pop_front());
          reqs_sent++;
        end
        if (pending_reqs.size() != 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid       <= 1'b1;
          in_cmd         <= pending_reqs[0].cmd;
          in_port        <= pending_reqs[0].port;
          in_local_addr  <= pending_reqs[0].local_addr;
          in_remote_addr <= pending_reqs[0].remote_addr;
          in_entry       <= pending_reqs[0].entry;
          in_active      <= pending_reqs[0].active;
          in_timer_sel   <= pending_reqs[0].timer_sel;
          in_time_value  <= pending_reqs[0].time_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: compare each accepted result against the oldest expectation.
  always @(posedge clk) begin
    rsp_t got;
    rsp_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_entry_index, out_expired_timer, out_next_wait, out_last};
      rsps_seen++;
      if (out_status == ST_EXPIRED) expiries_seen++;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result st=%0d idx=%0d tmr=%0d wait=%0d last=%0b",
                   $realtime, got.status, got.entry_index, got.expired_timer,
                   got.next_wait, got.last);
      end else begin
        exp_r = expected_rsps.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] mismatch exp st=%0d idx=%0d tmr=%0d wait=%0d last=%0b",
                      " | got st=%0d idx=%0d tmr=%0d wait=%0d last=%0b"},
                     $realtime, exp_r.status, exp_r.entry_index, exp_r.expired_timer,
                     exp_r.next_wait, exp_r.last, got.status, got.entry_index,
                     got.expired_timer, got.next_wait, got.last);
        end
      end
    end
  end

  function automatic req_t blank_req(cmd_t c);
    req_t q;
    q = '0;
    q.cmd = c;
    return q;
  endfunction

  function automatic req_t key_req(cmd_t c, int k);
    req_t q;
    q = blank_req(c);
    q.port = key_port[k];
    q.local_addr = key_local[k];
    q.remote_addr = key_remote[k];
    return q;
  endfunction

  function automatic req_t arm_req(int e, int t, logic [31:0] tv);
    req_t q;
    q = blank_req(CMD_ARM);
    q.entry = 4'(e);
    q.timer_sel = 2'(t);
    q.time_value = tv;
    return q;
  endfunction

  function automatic req_t act_req(int e, logic a);
    req_t q;
    q = blank_req(CMD_ACTIVE);
    q.entry = 4'(e);
    q.active = a;
    return q;
  endfunction

  function automatic req_t tick_req(logic [31:0] tv);
    req_t q;
    q = blank_req(CMD_TICK);
    q.time_value = tv;
    return q;
  endfunction

  // Wait for the queue and the table to drain.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_max_wait(logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_max_wait <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sh_max_wait = v;
  endtask

  // Random traffic: mostly connection life cycles on known keys, some noise.
  task automatic random_phase(int n);
    req_t q;
    int   k;
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(7);
      case ($urandom_range(9))
        0: begin
          q = key_req(CMD_FIND, k);
          if ($urandom_range(3) == 0) begin
            q.port = 8'($urandom);
            q.local_addr = 56'({$urandom, $urandom});
            q.remote_addr = 56'({$urandom, $urandom});
          end
        end
        1, 2: q = key_req(CMD_ALLOC, k);
        3: q = act_req($urandom_range(15), $urandom_range(3) != 0);
        4, 5: q = arm_req($urandom_range(15), $urandom_range(3),
                          now_time + $urandom_range(400));
        6: q = arm_req($urandom_range(15), $urandom_range(2),
                       ($urandom_range(7) == 0) ? 32'd0 : $urandom);
        7, 8: begin
          now_time = now_time + $urandom_range(200);
          q = tick_req(now_time);
        end
        default: begin
          q = $urandom;
          q.local_addr = 56'({$urandom, $urandom});
          q.remote_addr = 56'({$urandom, $urandom});
          q.time_value = $urandom;
          q.cmd = 3'($urandom_range(7));
        end
      endcase
      pending_reqs.push_back(q);
    end
  endtask

  initial begin
    req_t q;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_max_wait = '0;
    in_valid = 1'b0;
    in_cmd = '0;
    in_port = '0;
    in_local_addr = '0;
    in_remote_addr = '0;
    in_entry = '0;
    in_active = 1'b0;
    in_timer_sel = '0;
    in_time_value = '0;
    out_stall = 1'b0;
    table_reset();
    now_time = 32'd1000;
    for (int k = 0; k < 8; k++) begin
      key_port[k] = (k == 0) ? 8'hFF : 8'($urandom);
      key_local[k] = (k == 0) ? {56{1'b1}} : 56'({$urandom, $urandom});
      key_remote[k] = (k == 0) ? {56{1'b1}} : 56'({$urandom, $urandom});
    end
    key_port[1] = 8'h00;
    key_local[1] = '0;
    key_remote[1] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: miss on empty table, allocate, activate, find, full table.
    pending_reqs.push_back(key_req(CMD_FIND, 0));
    pending_reqs.push_back(key_req(CMD_ALLOC, 0));     // takes entry 15
    pending_reqs.push_back(key_req(CMD_FIND, 0));      // still inactive: miss
    pending_reqs.push_back(act_req(15, 1'b1));
    pending_reqs.push_back(key_req(CMD_ALLOC, 0));     // active match -> found
    pending_reqs.push_back(key_req(CMD_ALLOC, 1));     // takes entry 14
    pending_reqs.push_back(act_req(14, 1'b1));
    pending_reqs.push_back(arm_req(15, 0, 32'd5));
    pending_reqs.push_back(arm_req(15, 1, 32'hFFFF_FFFF));
    pending_reqs.push_back(arm_req(15, 2, 32'd7));
    pending_reqs.push_back(arm_req(14, 3, 32'd9));     // selector three: no-op
    pending_reqs.push_back(arm_req(3, 0, 32'd2));      // inactive entry, does not expire on these ticks
    pending_reqs.push_back(tick_req(32'd7));           // T1 and T3 of 15 expire
    pending_reqs.push_back(tick_req(32'hFFFF_FFFF));   // T2 at the top of time
    q = blank_req(CMD_TICK);
    q.cmd = 3'd7;                                      // unknown command
    pending_reqs.push_back(q);
    for (int e = 0; e < NUM_ENTRIES; e++) pending_reqs.push_back(act_req(e, 1'b1));
    pending_reqs.push_back(key_req(CMD_ALLOC, 2));     // table full
    drain();

    // max_wait extremes, with a full table still active
    write_max_wait(32'd1);
    pending_reqs.push_back(arm_req(0, 0, 32'd100));
    pending_reqs.push_back(tick_req(32'd10));
    drain();
    write_max_wait(32'hFFFF_FFFF);
    pending_reqs.push_back(tick_req(32'd10));
    pending_reqs.push_back(tick_req(32'd200));
    for (int e = 0; e < NUM_ENTRIES; e += 2) pending_reqs.push_back(act_req(e, 1'b0));
    drain();

    // Random phases with varied idling.
    write_max_wait(MAX_WAIT_RESET);
    send_idle_pct = 0;  recv_stall_pct = 0;
    random_phase(80);
    drain();
    write_max_wait(32'd150);
    send_idle_pct = 45; recv_stall_pct = 0;
    random_phase(80);
    drain();
    write_max_wait($urandom_range(1000, 1));
    send_idle_pct = 0;  recv_stall_pct = 45;
    random_phase(40);
    // sender holds off until every expectation has been met
    hold_sender = 1'b1;
    while (in_valid || expected_rsps.size() != 0) @(posedge clk);
    hold_sender = 1'b0;
    random_phase(40);
    drain();
    write_max_wait(32'd3600);
    send_idle_pct = 35; recv_stall_pct = 35;
    random_phase(90);
    drain();

    $display("Covered %0d requests and %0d results (%0d timer expiries),",
             reqs_sent, rsps_seen, expiries_seen);
    $display("across find/allocate/activate/arm/tick with four idling mixes.");
    if (mismatches == 0) begin
      $display("tb_link_connection_table_with_timers_core: done, clean");
    end else begin
      $display("tb_link_connection_table_with_timers_core: done, errors");
    end
    $finish;
  end

  // Watchdog: generous bound even with 49 results per tick under heavy stall.
  initial begin
    #20ms;
    $display("tb_link_connection_table_with_timers_core: done, errors");
    $finish;
  end
endmodule

FILE: filelist.f
sv/lct_pkg.sv
sv/link_connection_table_with_timers_core.sv
sim/tb_link_connection_table_with_timers_core.sv
